// File: design/ppdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppdt_pkg;

    // Store geometry: pixel fields, quotient search and dimension registers are sized for it
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;

    // Field and datapath widths
    localparam int LANE_W  = 20;              // one packed Q10.10 / Q1.18 component
    localparam int OFF_W   = LANE_W + 1;      // point minus origin
    localparam int DOT_W   = 43;              // Q.28 dot product
    localparam int SPLIT   = 22;              // low half of a dot product as a multiplier operand
    localparam int MUL_A_W = 23;
    localparam int MUL_B_W = 22;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 66;              // projection numerator and remainder
    localparam int Q_W     = 11;              // pixel quotient, one guard bit above 1023
    localparam int DIM_W   = 10;              // image width and height registers
    localparam int CFG_W   = 60;
    localparam int FS_W    = 20;
    localparam int STEP_W  = 6;
    localparam int DQ_SHIFT = 18;             // Q.28 to Q14.10
    localparam int DIV_PRE  = 19;             // 512 * 2^10: top divisor of the quotient search
    localparam logic [STEP_W-1:0] LAST_STEP = 6'd41;

    localparam logic OP_RENDER = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef enum logic [2:0] {
        REG_CAM_ORIGIN   = 3'd0,
        REG_AXIS_FORWARD = 3'd1,
        REG_AXIS_RIGHT   = 3'd2,
        REG_AXIS_UP      = 3'd3,
        REG_FOCAL_SCALE  = 3'd4,
        REG_IMAGE_WIDTH  = 3'd5,
        REG_IMAGE_HEIGHT = 3'd6
    } ppdt_reg_t;

    typedef struct packed {
        logic               op;
        logic signed [19:0] point_x;
        logic signed [19:0] point_y;
        logic signed [19:0] point_z;
        logic [23:0]        colour;
    } ppdt_in_t;

    typedef struct packed {
        logic [8:0]  pixel_x;
        logic [8:0]  pixel_y;
        logic [23:0] pixel_depth;
        logic [23:0] pixel_colour;
    } ppdt_out_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC,
        S_CHECK,
        S_TEST
    } ppdt_state_t;

    typedef enum logic [3:0] {
        A_OFF0, A_OFF1, A_OFF2,
        A_DLO, A_DHI, A_RLO, A_RHI, A_ULO, A_UHI
    } ppdt_asel_t;

    typedef enum logic [3:0] {
        B_F0, B_F1, B_F2,
        B_R0, B_R1, B_R2,
        B_U0, B_U1, B_U2,
        B_WP1, B_HP1, B_FS
    } ppdt_bsel_t;

    typedef enum logic [1:0] {
        DST_D, DST_R, DST_U, DST_T
    } ppdt_dst_t;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        ppdt_asel_t a_sel;
        ppdt_bsel_t b_sel;
        ppdt_dst_t  dst;
        logic       clr;
        logic       neg;
        logic [4:0] sh;
        logic       div_init;
        logic       div_step;
        logic       save_x;
        logic       save_y;
    } ppdt_cmd_t;

    typedef struct packed {
        logic           d_pos;
        logic           x_neg;
        logic           y_neg;
        logic [Q_W-1:0] qx;
        logic [Q_W-1:0] qy;
    } ppdt_stat_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_clear;
    } ppdt_mem_ctl_t;

    function automatic ppdt_cmd_t mac_op(input ppdt_asel_t a, input ppdt_bsel_t b,
                                         input ppdt_dst_t dst, input logic clr,
                                         input logic neg, input logic [4:0] sh);
        ppdt_cmd_t c;
        c        = '0;
        c.mul_en = 1'b1;
        c.a_sel  = a;
        c.b_sel  = b;
        c.dst    = dst;
        c.clr    = clr;
        c.neg    = neg;
        c.sh     = sh;
        return c;
    endfunction

    // Microprogram: dot products, horizontal numerator and quotient search,
    // then the vertical numerator and quotient search.
    function automatic ppdt_cmd_t ppdt_ucode(input logic [STEP_W-1:0] step);
        ppdt_cmd_t c;
        c = '0;
        unique case (step) inside
            6'd0:  c = mac_op(A_OFF0, B_F0, DST_D, 1'b1, 1'b0, 5'd0);
            6'd1:  c = mac_op(A_OFF1, B_F1, DST_D, 1'b0, 1'b0, 5'd0);
            6'd2:  c = mac_op(A_OFF2, B_F2, DST_D, 1'b0, 1'b0, 5'd0);
            6'd3:  c = mac_op(A_OFF0, B_R0, DST_R, 1'b1, 1'b0, 5'd0);
            6'd4:  c = mac_op(A_OFF1, B_R1, DST_R, 1'b0, 1'b0, 5'd0);
            6'd5:  c = mac_op(A_OFF2, B_R2, DST_R, 1'b0, 1'b0, 5'd0);
            6'd6:  c = mac_op(A_OFF0, B_U0, DST_U, 1'b1, 1'b0, 5'd0);
            6'd7:  c = mac_op(A_OFF1, B_U1, DST_U, 1'b0, 1'b0, 5'd0);
            6'd8:  c = mac_op(A_OFF2, B_U2, DST_U, 1'b0, 1'b0, 5'd0);
            6'd9:  c = mac_op(A_DLO, B_WP1, DST_T, 1'b1, 1'b0, 5'd8);
            6'd10: c = mac_op(A_DHI, B_WP1, DST_T, 1'b0, 1'b0, 5'd30);
            6'd11: c = mac_op(A_RLO, B_FS, DST_T, 1'b0, 1'b1, 5'd1);
            6'd12: c = mac_op(A_RHI, B_FS, DST_T, 1'b0, 1'b1, 5'd23);
            6'd13, 6'd29: c.div_init = 1'b1;
            [6'd14:6'd24], [6'd30:6'd40]: c.div_step = 1'b1;
            6'd25: begin
                c        = mac_op(A_DLO, B_HP1, DST_T, 1'b1, 1'b0, 5'd8);
                c.save_x = 1'b1;
            end
            6'd26: c = mac_op(A_DHI, B_HP1, DST_T, 1'b0, 1'b0, 5'd30);
            6'd27: c = mac_op(A_ULO, B_FS, DST_T, 1'b0, 1'b0, 5'd1);
            6'd28: c = mac_op(A_UHI, B_FS, DST_T, 1'b0, 1'b0, 5'd23);
            6'd41: c.save_y = 1'b1;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/ppdt_store.sv
`timescale 1ns / 1ps
`default_nettype none

module ppdt_store import ppdt_pkg::*; #(
    parameter int DEPTH_BITS = 24,
    parameter int ENTRIES    = 262144,
    parameter int ADDR_W     = 18
) (
    input  wire logic                  clk,
    input  wire ppdt_mem_ctl_t         ctl,
    input  wire logic [ADDR_W-1:0]     addr,
    input  wire logic [DEPTH_BITS-1:0] wr_data,
    output logic [DEPTH_BITS-1:0]      rd_data
);

    logic [DEPTH_BITS-1:0] mem [ENTRIES];
    logic [DEPTH_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/ppdt_arith.sv
`timescale 1ns / 1ps
`default_nettype none

module ppdt_arith import ppdt_pkg::*; #(
    parameter int DEPTH_BITS = 24
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ppdt_cmd_t             cmd,
    input  wire ppdt_in_t              point,
    input  wire logic [CFG_W-1:0]      cam_origin,
    input  wire logic [CFG_W-1:0]      axis_forward,
    input  wire logic [CFG_W-1:0]      axis_right,
    input  wire logic [CFG_W-1:0]      axis_up,
    input  wire logic [FS_W-1:0]       focal_scale,
    input  wire logic [DIM_W-1:0]      width_used,
    input  wire logic [DIM_W-1:0]      height_used,
    output ppdt_stat_t                 stat,
    output logic [DEPTH_BITS-1:0]      depth_q
);

    localparam int DQ_W = DOT_W - DQ_SHIFT;
    localparam int CMP_W = (DQ_W > DEPTH_BITS) ? DQ_W : DEPTH_BITS;
    localparam logic [CMP_W-1:0] DEPTH_MAX_C = CMP_W'({DEPTH_BITS{1'b1}});

    logic signed [OFF_W-1:0]   off_reg [3];
    logic signed [DOT_W-1:0]   d_reg, r_reg, u_reg;
    logic signed [ACC_W-1:0]   t_reg, dv_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    ppdt_cmd_t                 pcmd_reg;
    logic                      acc_en_reg;
    logic [Q_W-1:0]            q_reg, qx_reg, qy_reg;
    logic                      x_neg_reg, y_neg_reg;

    logic signed [MUL_A_W-1:0] a_op;
    logic signed [MUL_B_W-1:0] b_op;
    logic [DIM_W:0]            wp1, hp1;
    logic signed [ACC_W-1:0]   base, shifted, sum;
    logic                      ge;
    logic [DOT_W-1:0]          d_round;
    logic [CMP_W-1:0]          dq_c;

    assign wp1 = {1'b0, width_used} + 11'd1;
    assign hp1 = {1'b0, height_used} + 11'd1;

    always_comb
    begin
        unique case (cmd.a_sel)
            A_OFF0:  a_op = MUL_A_W'(off_reg[0]);
            A_OFF1:  a_op = MUL_A_W'(off_reg[1]);
            A_OFF2:  a_op = MUL_A_W'(off_reg[2]);
            A_DLO:   a_op = {1'b0, d_reg[SPLIT-1:0]};
            A_DHI:   a_op = MUL_A_W'($signed(d_reg[DOT_W-1:SPLIT]));
            A_RLO:   a_op = {1'b0, r_reg[SPLIT-1:0]};
            A_RHI:   a_op = MUL_A_W'($signed(r_reg[DOT_W-1:SPLIT]));
            A_ULO:   a_op = {1'b0, u_reg[SPLIT-1:0]};
            A_UHI:   a_op = MUL_A_W'($signed(u_reg[DOT_W-1:SPLIT]));
            default: a_op = '0;
        endcase
        unique case (cmd.b_sel)
            B_F0:    b_op = MUL_B_W'($signed(axis_forward[19:0]));
            B_F1:    b_op = MUL_B_W'($signed(axis_forward[39:20]));
            B_F2:    b_op = MUL_B_W'($signed(axis_forward[59:40]));
            B_R0:    b_op = MUL_B_W'($signed(axis_right[19:0]));
            B_R1:    b_op = MUL_B_W'($signed(axis_right[39:20]));
            B_R2:    b_op = MUL_B_W'($signed(axis_right[59:40]));
            B_U0:    b_op = MUL_B_W'($signed(axis_up[19:0]));
            B_U1:    b_op = MUL_B_W'($signed(axis_up[39:20]));
            B_U2:    b_op = MUL_B_W'($signed(axis_up[59:40]));
            B_WP1:   b_op = $signed({11'b0, wp1});
            B_HP1:   b_op = $signed({11'b0, hp1});
            B_FS:    b_op = $signed({2'b0, focal_scale});
            default: b_op = '0;
        endcase
    end

    // accumulate the registered product in the cycle after it is formed
    always_comb
    begin
        unique case (pcmd_reg.dst)
            DST_D:   base = ACC_W'(d_reg);
            DST_R:   base = ACC_W'(r_reg);
            DST_U:   base = ACC_W'(u_reg);
            default: base = t_reg;
        endcase
        shifted = ACC_W'(prod_reg) <<< pcmd_reg.sh;
        sum = (pcmd_reg.clr ? '0 : base) + (pcmd_reg.neg ? -shifted : shifted);
    end

    assign ge = (t_reg >= dv_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_en_reg <= 1'b0;
        end
        else
        begin
            acc_en_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            off_reg[0] <= OFF_W'(point.point_x) - OFF_W'($signed(cam_origin[19:0]));
            off_reg[1] <= OFF_W'(point.point_y) - OFF_W'($signed(cam_origin[39:20]));
            off_reg[2] <= OFF_W'(point.point_z) - OFF_W'($signed(cam_origin[59:40]));
        end
        prod_reg <= a_op * b_op;
        pcmd_reg <= cmd;
        if (acc_en_reg)
        begin
            unique case (pcmd_reg.dst)
                DST_D:   d_reg <= sum[DOT_W-1:0];
                DST_R:   r_reg <= sum[DOT_W-1:0];
                DST_U:   u_reg <= sum[DOT_W-1:0];
                default: t_reg <= sum;
            endcase
        end
        else if (cmd.div_step && ge)
        begin
            t_reg <= t_reg - dv_reg;
        end
        if (cmd.div_init)
        begin
            dv_reg <= $signed(ACC_W'({d_reg, {DIV_PRE{1'b0}}}));
            q_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            dv_reg <= dv_reg >>> 1;
            q_reg  <= {q_reg[Q_W-2:0], ge};
        end
        // a negative numerator never passes a compare, so its sign survives the search
        if (cmd.save_x)
        begin
            qx_reg    <= q_reg;
            x_neg_reg <= t_reg[ACC_W-1];
        end
        if (cmd.save_y)
        begin
            qy_reg    <= q_reg;
            y_neg_reg <= t_reg[ACC_W-1];
        end
    end

    assign d_round = d_reg + DOT_W'(1 << (DQ_SHIFT - 1));
    assign dq_c    = CMP_W'(d_round[DOT_W-1:DQ_SHIFT]);
    assign depth_q = (dq_c > DEPTH_MAX_C) ? {DEPTH_BITS{1'b1}} : dq_c[DEPTH_BITS-1:0];

    assign stat.d_pos = !d_reg[DOT_W-1] && (|d_reg);
    assign stat.x_neg = x_neg_reg;
    assign stat.y_neg = y_neg_reg;
    assign stat.qx    = qx_reg;
    assign stat.qy    = qy_reg;

endmodule

`default_nettype wire

// File: design/ppdt_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module ppdt_seq import ppdt_pkg::*; #(
    parameter int DEPTH_BITS = 24,
    parameter int ADDR_W     = 18
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_op,
    input  wire logic                  out_blocked,
    input  wire ppdt_stat_t            stat,
    input  wire logic [DIM_W-1:0]      width_used,
    input  wire logic [DIM_W-1:0]      height_used,
    input  wire logic [DEPTH_BITS-1:0] depth_q,
    input  wire logic [DEPTH_BITS-1:0] rd_data,
    output logic                       in_stall,
    output ppdt_cmd_t                  cmd,
    output ppdt_mem_ctl_t              mem_ctl,
    output logic [ADDR_W-1:0]          mem_addr,
    output logic [DEPTH_BITS-1:0]      mem_wdata,
    output logic                       emit
);

    localparam int ENTRIES = MAX_WIDTH * MAX_HEIGHT;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRIES - 1);

    ppdt_state_t         state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                fits, closer;
    logic [ADDR_W-1:0]   pix_addr;

    assign fits = stat.d_pos && !stat.x_neg && !stat.y_neg
               && (stat.qx < Q_W'(width_used)) && (stat.qy < Q_W'(height_used));
    assign pix_addr = ADDR_W'(stat.qy) * ADDR_W'(MAX_WIDTH) + ADDR_W'(stat.qx);
    assign closer   = depth_q < rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            step_reg    <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        clr_cnt_next = clr_cnt_reg;
        in_stall     = 1'b1;
        cmd          = '0;
        mem_ctl      = '0;
        mem_addr     = pix_addr;
        mem_wdata    = depth_q;
        emit         = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_ctl.wr_en    = 1'b1;
                mem_ctl.wr_clear = 1'b1;
                mem_addr         = clr_cnt_reg;
                mem_wdata        = {DEPTH_BITS{1'b1}};
                clr_cnt_next     = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    clr_cnt_next = '0;
                    state_next   = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (in_op == OP_CLEAR)
                    begin
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        step_next  = '0;
                        state_next = S_CALC;
                    end
                end
            end
            S_CALC:
            begin
                cmd       = ppdt_ucode(step_reg);
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (fits)
                begin
                    mem_ctl.rd_en = 1'b1;
                    state_next    = S_TEST;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_TEST:
            begin
                if (!closer)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_blocked)
                begin
                    mem_ctl.wr_en = 1'b1;
                    emit          = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !out_blocked)
        else $error("pixel emitted while the output register is held");

    a_write_closer: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctl.wr_en && !mem_ctl.wr_clear) |-> (closer && emit))
        else $error("depth store written without a closer depth");

    a_clear_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid && in_op == OP_CLEAR) |=> state_reg == S_CLEAR)
        else $error("clear transaction did not start a sweep");
`endif

endmodule

`default_nettype wire

// File: design/point_projection_depth_test.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Handshake              Payload
// in         input      in_valid / in_stall    in_data (ppdt_in_t): op, point, colour
// out        output     out_valid / out_stall  out_data (ppdt_out_t): pixel x, y, depth, colour
// cfg        input      cfg_valid / cfg_ready  cfg_index (register), cfg_data (value)
//
// A render transaction that reaches the depth test runs from acceptance to the next
// possible acceptance through 42 microcode steps on the one shared multiply-accumulate
// and compare-subtract unit (nine dot-product multiplies, two 4-multiply numerators,
// two 11-step quotient searches), then the depth store read and then the compare and
// write. A point behind the camera or off the image skips the store read. A clear
// transaction and the sweep after reset write all MAX_WIDTH*MAX_HEIGHT store
// entries (262144), one store entry per cycle; in is stalled meanwhile, cfg stays
// open. A result is held in the output register while out stalls; the next
// transaction is still accepted, but its pixel write waits in the compare step and
// stalls in until the register drains.
module point_projection_depth_test import ppdt_pkg::*; #(
    parameter int DEPTH_BITS = 24
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire ppdt_in_t          in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output ppdt_out_t              out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    localparam int ENTRIES = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = $clog2(ENTRIES);

    // configuration registers
    logic [CFG_W-1:0] cam_origin_reg, axis_forward_reg, axis_right_reg, axis_up_reg;
    logic [FS_W-1:0]  focal_scale_reg;
    logic [DIM_W-1:0] image_width_reg, image_height_reg;
    logic [DIM_W-1:0] width_used, height_used;

    logic             out_valid_reg;
    ppdt_out_t        out_data_reg;
    logic [23:0]      colour_reg;

    ppdt_cmd_t             cmd;
    ppdt_stat_t            stat;
    ppdt_mem_ctl_t         mem_ctl;
    logic [ADDR_W-1:0]     mem_addr;
    logic [DEPTH_BITS-1:0] mem_wdata, rd_data, depth_q;
    logic                  emit, out_blocked;

    // always take a register write; the host writes only while idle, a rule the block does not enforce
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_origin_reg   <= '0;
            axis_forward_reg <= '0;
            axis_right_reg   <= '0;
            axis_up_reg      <= '0;
            focal_scale_reg  <= 20'd256;
            image_width_reg  <= 10'd512;
            image_height_reg <= 10'd512;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CAM_ORIGIN:   cam_origin_reg   <= cfg_data;
                REG_AXIS_FORWARD: axis_forward_reg <= cfg_data;
                REG_AXIS_RIGHT:   axis_right_reg   <= cfg_data;
                REG_AXIS_UP:      axis_up_reg      <= cfg_data;
                REG_FOCAL_SCALE:  focal_scale_reg  <= cfg_data[FS_W-1:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[DIM_W-1:0];
                default:          ;  // drop writes beyond the register list
            endcase
        end
    end

    // clip the image to the store; the clipped size also sets the image centre
    assign width_used  = (32'(image_width_reg) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH)
                                                             : image_width_reg;
    assign height_used = (32'(image_height_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT)
                                                               : image_height_reg;

    // hold the colour of the point in flight
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            colour_reg <= in_data.colour;
        end
    end

    ppdt_seq #(
        .DEPTH_BITS (DEPTH_BITS),
        .ADDR_W     (ADDR_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_op       (in_data.op),
        .out_blocked (out_blocked),
        .stat        (stat),
        .width_used  (width_used),
        .height_used (height_used),
        .depth_q     (depth_q),
        .rd_data     (rd_data),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .mem_ctl     (mem_ctl),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata),
        .emit        (emit)
    );

    ppdt_arith #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_arith (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .point        (in_data),
        .cam_origin   (cam_origin_reg),
        .axis_forward (axis_forward_reg),
        .axis_right   (axis_right_reg),
        .axis_up      (axis_up_reg),
        .focal_scale  (focal_scale_reg),
        .width_used   (width_used),
        .height_used  (height_used),
        .stat         (stat),
        .depth_q      (depth_q)
    );

    ppdt_store #(
        .DEPTH_BITS (DEPTH_BITS),
        .ENTRIES    (ENTRIES),
        .ADDR_W     (ADDR_W)
    ) u_store (
        .clk     (clk),
        .ctl     (mem_ctl),
        .addr    (mem_addr),
        .wr_data (mem_wdata),
        .rd_data (rd_data)
    );

    // output register: a held result blocks only a new emit, never acceptance
    assign out_blocked = out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg.pixel_x      <= stat.qx[8:0];
            out_data_reg.pixel_y      <= stat.qy[8:0];
            out_data_reg.pixel_depth  <= 24'(depth_q);
            out_data_reg.pixel_colour <= colour_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps

import ppdt_pkg::*;

// Tracks the depth store and the camera registers, predicts the pixel writes
// that each accepted transaction causes and checks what the block emits.
class depth_scoreboard;
    localparam int STORE_W = 512;
    localparam int STORE_H = 512;
    localparam logic [23:0] DEPTH_FAR = 24'hFFFFFF;

    logic [59:0] origin_q;
    logic [59:0] fwd_q;
    logic [59:0] right_q;
    logic [59:0] up_q;
    logic [19:0] focal_q;
    logic [9:0]  width_q;
    logic [9:0]  height_q;
    logic [23:0] depth_q [0:STORE_W*STORE_H-1];
    ppdt_out_t   pixel_q[$];
    int          errors;

    function new();
        origin_q = '0;
        fwd_q    = '0;
        right_q  = '0;
        up_q     = '0;
        focal_q  = 20'd256;
        width_q  = 10'd512;
        height_q = 10'd512;
        errors   = 0;
        wipe_depths();
    endfunction

    function void wipe_depths();
        foreach (depth_q[i])
            depth_q[i] = DEPTH_FAR;
    endfunction

    function void set_reg(logic [2:0] idx, logic [59:0] value);
        case (idx)
            REG_CAM_ORIGIN:   origin_q = value;
            REG_AXIS_FORWARD: fwd_q    = value;
            REG_AXIS_RIGHT:   right_q  = value;
            REG_AXIS_UP:      up_q     = value;
            REG_FOCAL_SCALE:  focal_q  = value[19:0];
            REG_IMAGE_WIDTH:  width_q  = value[9:0];
            REG_IMAGE_HEIGHT: height_q = value[9:0];
            default: ;
        endcase
    endfunction

    function longint lane_of(logic [59:0] packed_v, int k);
        logic signed [19:0] v;
        v = packed_v[20*k +: 20];
        return v;
    endfunction

    // Round (size*128*d + fc) / (256*d) to nearest, ties up; -1 when negative.
    function longint pixel_of(longint size, longint d, logic signed [127:0] fc);
        logic signed [127:0] den;
        logic signed [127:0] twice;
        den   = 128'sd256 * d;
        twice = 2 * (128'sd128 * size * d + fc) + den;
        if (twice < 0)
            return -1;
        return longint'(twice / (2 * den));
    endfunction

    function void note_point(ppdt_in_t it);
        longint off [3];
        longint d, r, u, w, h, px, py, dq;
        int idx;
        ppdt_out_t pix;
        if (it.op == OP_CLEAR) begin
            wipe_depths();
            return;
        end
        off[0] = longint'(it.point_x) - lane_of(origin_q, 0);
        off[1] = longint'(it.point_y) - lane_of(origin_q, 1);
        off[2] = longint'(it.point_z) - lane_of(origin_q, 2);
        d = 0; r = 0; u = 0;
        for (int k = 0; k < 3; k++) begin
            d += off[k] * lane_of(fwd_q, k);
            r += off[k] * lane_of(right_q, k);
            u += off[k] * lane_of(up_q, k);
        end
        if (d <= 0)
            return;
        w  = (width_q > STORE_W) ? STORE_W : width_q;
        h  = (height_q > STORE_H) ? STORE_H : height_q;
        px = pixel_of(w, d, -(128'(signed'({1'b0, focal_q})) * r));
        py = pixel_of(h, d, 128'(signed'({1'b0, focal_q})) * u);
        if (px < 0 || py < 0 || px >= w || py >= h)
            return;
        dq = (d + (longint'(1) << 17)) >>> 18;
        if (dq > DEPTH_FAR)
            dq = DEPTH_FAR;
        idx = int'(py) * STORE_W + int'(px);
        if (dq >= depth_q[idx])
            return;
        depth_q[idx]     = dq[23:0];
        pix.pixel_x      = px[8:0];
        pix.pixel_y      = py[8:0];
        pix.pixel_depth  = dq[23:0];
        pix.pixel_colour = it.colour;
        pixel_q.push_back(pix);
    endfunction

    task report(string what, longint got, longint want);
        $display("mismatch %s: got %0h, expected %0h", what, got, want);
        errors++;
    endtask

    task check_pixel(ppdt_out_t got);
        ppdt_out_t want;
        if (pixel_q.size() == 0) begin
            report("unexpected pixel write", longint'(got.pixel_depth), 0);
            return;
        end
        want = pixel_q.pop_front();
        if (got.pixel_x != want.pixel_x)
            report("pixel_x", got.pixel_x, want.pixel_x);
        if (got.pixel_y != want.pixel_y)
            report("pixel_y", got.pixel_y, want.pixel_y);
        if (got.pixel_depth != want.pixel_depth)
            report("pixel_depth", got.pixel_depth, want.pixel_depth);
        if (got.pixel_colour != want.pixel_colour)
            report("pixel_colour", got.pixel_colour, want.pixel_colour);
    endtask
endclass

module tb;
    // Longer than a full store sweep, so a clear never trips it.
    localparam int IDLE_LIMIT = 1000000;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int PHASE_ITEMS = 155;
    localparam int SQUEEZE_CYCLES = 3000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    ppdt_in_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    ppdt_out_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [59:0] cfg_data = '0;

    depth_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  squeeze_req = 1'b0;

    point_projection_depth_test i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Check each pixel write and watch for a hang: count cycles with no
    // transaction on any channel.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_pixel(out_data);
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver side: random stalls, plus one long hold-off on request so the
    // output register fills and the block backs up its input.
    initial
    begin
        int n;
        @(posedge clk);
        forever begin
            if (squeeze_req) begin
                out_stall <= 1'b1;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                squeeze_req = 1'b0;
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [59:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold the item until the block takes it, then note it for prediction.
    task automatic send_item(ppdt_in_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        sb.note_point(it);
    endtask

    task automatic send_point(longint x, longint y, longint z, logic [23:0] colour);
        ppdt_in_t it;
        it.op      = OP_RENDER;
        it.point_x = x[19:0];
        it.point_y = y[19:0];
        it.point_z = z[19:0];
        it.colour  = colour;
        send_item(it);
    endtask

    task automatic send_clear();
        ppdt_in_t it;
        it        = '0;
        it.op     = OP_CLEAR;
        it.colour = 24'($urandom());
        send_item(it);
    endtask

    // Drain all pending pixel writes; give a render with no result time to finish.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (sb.pixel_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [59:0] pack3(longint a, longint b, longint c);
        return {c[19:0], b[19:0], a[19:0]};
    endfunction

    task automatic setup_camera(longint ox, longint oy, longint oz, longint sf, longint sr,
                                longint su, logic [19:0] fs, logic [9:0] w, logic [9:0] h);
        write_reg(REG_CAM_ORIGIN, pack3(ox, oy, oz));
        write_reg(REG_AXIS_FORWARD, pack3(0, 0, sf <<< 18));
        write_reg(REG_AXIS_RIGHT, pack3(sr <<< 18, 0, 0));
        write_reg(REG_AXIS_UP, pack3(0, su <<< 18, 0));
        write_reg(REG_FOCAL_SCALE, 60'(fs));
        write_reg(REG_IMAGE_WIDTH, 60'(w));
        write_reg(REG_IMAGE_HEIGHT, 60'(h));
    endtask

    initial
    begin
        longint ox, oy, oz, sf, sr, su, c, a, b, lim, wlim, hlim;
        logic [19:0] fs;
        logic [9:0]  w, h;
        bit          free_axes;
        ppdt_in_t    it;
        logic [95:0] raw;
        ppdt_out_t   lost;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: plain camera looking down +z, focal scale 256 px per unit.
        setup_camera(0, 0, 0, 1, 1, 1, 20'h10000, 10'd512, 10'd512);
        write_reg(REG_UNUSED, {60{1'b1}});
        send_point(0, 0, 1024, 24'hFFFFFF);           // image center
        send_point(0, 0, 2048, 24'h123456);           // farther: loses the depth test
        send_point(0, 0, 512, 24'h000000);            // nearer: wins
        send_point(0, 0, 0, 24'hABCDEF);              // zero depth
        send_point(5, 7, -1024, 24'h00FF00);          // behind the camera
        send_point(-524288, 524287, 524287, 24'h0000FF);
        send_point(524287, -524288, 524287, 24'hFF0000);
        send_point(1, 0, 512, 24'h111111);            // horizontal tie
        send_point(0, 1, 512, 24'h222222);            // vertical tie
        send_point(-1, -1, 512, 24'h333333);
        send_point(524287, 524287, 1, 24'h444444);    // far outside the image
        send_point(-300, 400, 524287, 24'h555555);    // deep point
        send_clear();
        send_point(0, 0, 1024, 24'h666666);           // accepted again after the clear
        wait_quiet();

        for (int p = 0; p < 6; p++) begin
            wait_quiet();
            ox = longint'($urandom_range(0, 1 << 18)) - (1 << 17);
            oy = longint'($urandom_range(0, 1 << 18)) - (1 << 17);
            oz = longint'($urandom_range(0, 1 << 18)) - (1 << 17);
            sf = $urandom_range(0, 1) ? 1 : -1;
            sr = $urandom_range(0, 1) ? 1 : -1;
            su = $urandom_range(0, 1) ? 1 : -1;
            fs = 20'($urandom_range(1 << 12, 1 << 18));
            w  = 10'($urandom_range(16, 512));
            h  = 10'($urandom_range(16, 512));
            free_axes = 1'b0;
            case (p)
                0: begin fs = 20'h10000; w = 10'd512; h = 10'd512; end
                2: begin fs = 20'hFFFFF; w = 10'h3FF; h = 10'h3FF; end
                3: begin fs = 20'd256; w = 10'd1; h = 10'd1; end
                4: free_axes = 1'b1;
                default: ;
            endcase
            setup_camera(ox, oy, oz, sf, sr, su, fs, w, h);
            if (free_axes) begin
                // Arbitrary axes and an all-ones origin: mostly off-image noise.
                write_reg(REG_CAM_ORIGIN, {60{1'b1}});
                write_reg(REG_AXIS_FORWARD, 60'({$urandom(), $urandom()}));
                write_reg(REG_AXIS_RIGHT, 60'({$urandom(), $urandom()}));
                write_reg(REG_AXIS_UP, 60'({$urandom(), $urandom()}));
                write_reg(REG_FOCAL_SCALE, '0);
            end
            wlim = (w > 512) ? 512 : w;
            hlim = (h > 512) ? 512 : h;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == 20)
                    squeeze_req = 1'b1;
                if (p == 3 && n == 0)
                    send_clear();
                if ($urandom_range(0, 6) == 0) begin
                    // Noise: any point at all.
                    raw       = {$urandom(), $urandom(), $urandom()};
                    it        = raw[84:0];
                    it.op     = OP_RENDER;
                    send_item(it);
                end else begin
                    // Camera-space point inside the view cone, moved to world space.
                    c = $urandom_range(0, 7) == 0 ? $urandom_range(1, 64)
                                                  : $urandom_range(64, 1 << 18);
                    lim = (fs == 0) ? (1 << 18) : (c * wlim * 128) / fs;
                    if (lim > (1 << 18))
                        lim = 1 << 18;
                    a = longint'($urandom_range(0, 2 * lim)) - lim;
                    lim = (fs == 0) ? (1 << 18) : (c * hlim * 128) / fs;
                    if (lim > (1 << 18))
                        lim = 1 << 18;
                    b = longint'($urandom_range(0, 2 * lim)) - lim;
                    send_point(ox + sr * a, oy + su * b, oz + sf * c, 24'($urandom()));
                end
            end
        end

        wait_quiet();
        repeat (100) @(posedge clk);
        while (sb.pixel_q.size() != 0) begin
            lost = sb.pixel_q.pop_front();
            sb.report("pixel write never arrived", 0, longint'(lost.pixel_depth));
        end
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// File: filelist.f
design/ppdt_pkg.sv
design/ppdt_store.sv
design/ppdt_arith.sv
design/ppdt_seq.sv
design/point_projection_depth_test.sv
test/tb.sv
